@@ hdl/ffba_pkg.sv @@
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int NUM_CHUNKS      = 4;
  localparam int CHUNK_BYTES     = 4096;
  localparam int HEADER_BYTES    = 32;
  localparam int OVERHEAD_BYTES  = 8;
  localparam int MIN_SPLIT_BYTES = 16;
  localparam int TABLE_DEPTH     = 64;
  localparam int CONT_RESERVE    =
    ((MIN_SPLIT_BYTES > OVERHEAD_BYTES) ? MIN_SPLIT_BYTES : OVERHEAD_BYTES) + 100;
  localparam int LIVE_DEPTH      = NUM_CHUNKS * TABLE_DEPTH;

  localparam int REQ_W   = 13;
  localparam int ADDR_W  = 14;
  localparam int OFF_W   = $clog2(CHUNK_BYTES);
  localparam int LEN_W   = OFF_W + 1;
  localparam int CH_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int K_W     = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = K_W + 1;
  localparam int SEG_AW  = CH_W + K_W;
  localparam int LIVE_AW = $clog2(LIVE_DEPTH);
  localparam int LIVE_CW = LIVE_AW + 1;
  localparam int GA_W    = CH_W + OFF_W;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_LARGE   = 3'd2;
  localparam logic [2:0] ST_NOFIT   = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;
  localparam logic [2:0] ST_UNKNOWN = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  localparam logic CMD_ALLOC = 1'b0;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] off;
  } seg_t;

  typedef struct packed {
    logic [GA_W-1:0]  addr;
    logic [LEN_W-1:0] len;
  } live_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE,
    S_A_NEXT, S_A_CHK, S_A_SLOT,
    S_SD_NEXT, S_SD_WR,
    S_F_LRD, S_F_LCHK, S_F_SNEXT, S_F_SCHK, S_F_MERGE,
    S_SU_NEXT, S_SU_WR, S_F_DONE
  } state_t;

  // first free byte of a chunk after its header, and after the reserve in chunk 0
  function automatic logic [LEN_W:0] first_off(input logic [CH_W-1:0] c);
    first_off = (LEN_W+1)'(HEADER_BYTES + ((c == '0) ? CONT_RESERVE : 0));
  endfunction

  function automatic logic [CNT_W-1:0] init_cnt(input logic [CH_W-1:0] c);
    init_cnt = (first_off(c) < (LEN_W+1)'(CHUNK_BYTES)) ? CNT_W'(1) : '0;
  endfunction

endpackage

@@ hdl/ffba_ram.sv @@
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write one word, read one word with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/first_fit_block_allocator.sv @@
`timescale 1ns / 1ps
// First-fit block allocator over NUM_CHUNKS arenas with coalescing free lists.
// Command channel: a beat is taken when start is high and busy is low; cmd picks
// allocate (req_size) or free (block_addr, is_null, free_size).
// Result channel: done is high for one cycle with status and result_addr; the
// receiver takes every result and cannot stall the block.
// One command is worked at a time; busy stays high until its result strobes.
// Allocate: scans free segments in chunk order, shifts entries down when a
// segment is used whole, then picks a free live-table slot. Free: searches
// the live table, scans free segments, and shifts entries on insert or merge.
// Zero, oversize and ignored commands answer the next cycle.
// The segment table and live table sit in single-read, single-write RAMs with
// a registered read output; every step is a read, then a compare and write.
// After reset the block writes the initial segment of each chunk with busy
// high, then goes idle.
module first_fit_block_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd,
  input  logic [ffba_pkg::REQ_W-1:0]  req_size,
  input  logic [ffba_pkg::ADDR_W-1:0] block_addr,
  input  logic                        is_null,
  input  logic [ffba_pkg::REQ_W-1:0]  free_size,
  output logic                        done,
  output logic [2:0]                  status,
  output logic [ffba_pkg::ADDR_W-1:0] result_addr
);
  import ffba_pkg::*;

  state_t state, state_next;

  logic [CH_W-1:0]    ch;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   j;
  logic [LIVE_AW-1:0] sc;
  logic [LEN_W-1:0]   need;
  logic [OFF_W-1:0]   off_f;
  logic [LEN_W-1:0]   len_f;
  logic [ADDR_W-1:0]  baddr;
  logic               ret_alloc;
  logic               cur_ok;
  seg_t               cur, prev;
  logic [CNT_W-1:0]   seg_cnt [NUM_CHUNKS];
  logic [LIVE_DEPTH-1:0] live_valid;
  logic [LIVE_CW-1:0] live_cnt;

  logic              seg_we;
  logic [SEG_AW-1:0] seg_waddr, seg_raddr;
  seg_t              seg_wdata, seg_rd;
  logic               live_we;
  logic [LIVE_AW-1:0] live_waddr;
  live_t              live_wdata, live_rd;

  ffba_ram #(.DATA_W($bits(seg_t)), .DEPTH(NUM_CHUNKS * TABLE_DEPTH)) u_seg_ram (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
    .raddr(seg_raddr), .rdata(seg_rd)
  );

  ffba_ram #(.DATA_W($bits(live_t)), .DEPTH(LIVE_DEPTH)) u_live_ram (
    .clk(clk), .we(live_we), .waddr(live_waddr), .wdata(live_wdata),
    .raddr(sc), .rdata(live_rd)
  );

  // decision terms
  logic [CNT_W-1:0]  n_ch;
  logic              fit, split, lmatch, mnext, mprev, chk_last;
  logic [ADDR_W-1:0] fstart;
  logic [GA_W-1:0]   alloc_addr;
  logic [LEN_W-1:0]  blen;

  assign busy     = (state != S_IDLE);
  assign n_ch     = seg_cnt[ch];
  assign chk_last = (ch == CH_W'(NUM_CHUNKS - 1));
  assign fit      = (seg_rd.len >= need);
  assign split    = ((seg_rd.len - need) >= LEN_W'(MIN_SPLIT_BYTES));
  assign lmatch   = live_valid[sc] && (ADDR_W'(live_rd.addr) == baddr);
  assign fstart   = baddr - ADDR_W'(OVERHEAD_BYTES);
  assign mnext    = cur_ok && ((LEN_W'(off_f) + len_f) == LEN_W'(cur.off));
  assign mprev    = (k != '0) && ((LEN_W'(prev.off) + prev.len) == LEN_W'(off_f));
  assign alloc_addr = GA_W'({ch, off_f}) + GA_W'(OVERHEAD_BYTES);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:    if (chk_last) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (cmd == CMD_ALLOC) begin
            if (req_size != '0 && req_size <= REQ_W'(CHUNK_BYTES - HEADER_BYTES))
              state_next = S_A_NEXT;
          end else if (!is_null && free_size != '0) begin
            state_next = S_F_LRD;
          end
        end
      end
      S_A_NEXT: begin
        if (k < n_ch) state_next = S_A_CHK;
        else if (chk_last) state_next = S_IDLE;
      end
      S_A_CHK: begin
        if (!fit) state_next = S_A_NEXT;
        else if (live_cnt == LIVE_CW'(LIVE_DEPTH)) state_next = S_IDLE;
        else if (split) state_next = S_A_SLOT;
        else state_next = S_SD_NEXT;
      end
      S_A_SLOT:  if (!live_valid[sc]) state_next = S_IDLE;
      S_SD_NEXT: begin
        if ((k + CNT_W'(1)) < n_ch) state_next = S_SD_WR;
        else state_next = ret_alloc ? S_A_SLOT : S_F_DONE;
      end
      S_SD_WR:   state_next = S_SD_NEXT;
      S_F_LRD:   state_next = S_F_LCHK;
      S_F_LCHK: begin
        if (lmatch) state_next = S_F_SNEXT;
        else if (sc == LIVE_AW'(LIVE_DEPTH - 1)) state_next = S_IDLE;
        else state_next = S_F_LRD;
      end
      S_F_SNEXT: state_next = (k < n_ch) ? S_F_SCHK : S_F_MERGE;
      S_F_SCHK:  state_next = (seg_rd.off > off_f) ? S_F_MERGE : S_F_SNEXT;
      S_F_MERGE: begin
        if (mprev && mnext) state_next = S_SD_NEXT;
        else if (mprev || mnext) state_next = S_F_DONE;
        else if (n_ch >= CNT_W'(TABLE_DEPTH)) state_next = S_IDLE;
        else state_next = S_SU_NEXT;
      end
      S_SU_NEXT: state_next = (j > k) ? S_SU_WR : S_F_DONE;
      S_SU_WR:   state_next = S_SU_NEXT;
      S_F_DONE:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory port drive
  always_comb begin
    seg_we     = 1'b0;
    seg_waddr  = {ch, k[K_W-1:0]};
    seg_wdata  = seg_rd;
    seg_raddr  = {ch, k[K_W-1:0]};
    live_we    = 1'b0;
    live_waddr = sc;
    live_wdata = '{addr: alloc_addr, len: blen};
    unique case (state)
      S_INIT: begin
        seg_we    = 1'b1;
        seg_waddr = {ch, K_W'(0)};
        seg_wdata = '{len: LEN_W'((LEN_W+1)'(CHUNK_BYTES) - first_off(ch)),
                      off: OFF_W'(first_off(ch))};
      end
      S_A_CHK: begin
        seg_we    = fit && split && (live_cnt != LIVE_CW'(LIVE_DEPTH));
        seg_wdata = '{len: seg_rd.len - need, off: seg_rd.off + OFF_W'(need)};
      end
      S_A_SLOT:  live_we = !live_valid[sc];
      S_SD_NEXT: seg_raddr = {ch, K_W'(k + CNT_W'(1))};
      S_SD_WR:   seg_we = 1'b1;
      S_F_MERGE: begin
        if (mprev) begin
          seg_we    = 1'b1;
          seg_waddr = {ch, K_W'(k - CNT_W'(1))};
          seg_wdata = '{len: prev.len + len_f + (mnext ? cur.len : LEN_W'(0)),
                        off: prev.off};
        end else if (mnext) begin
          seg_we    = 1'b1;
          seg_wdata = '{len: cur.len + len_f, off: off_f};
        end
      end
      S_SU_NEXT: begin
        seg_raddr = {ch, K_W'(j - CNT_W'(1))};
        if (!(j > k)) begin
          seg_we    = 1'b1;
          seg_wdata = '{len: len_f, off: off_f};
        end
      end
      S_SU_WR: begin
        seg_we    = 1'b1;
        seg_waddr = {ch, j[K_W-1:0]};
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // datapath and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      ch         <= '0;
      done       <= 1'b0;
      live_valid <= '0;
      live_cnt   <= '0;
      for (int c = 0; c < NUM_CHUNKS; c++) seg_cnt[c] <= init_cnt(CH_W'(c));
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: ch <= ch + CH_W'(1);
        S_IDLE: begin
          if (start) begin
            baddr       <= block_addr;
            need        <= LEN_W'(req_size) + LEN_W'(OVERHEAD_BYTES);
            ch          <= '0;
            k           <= '0;
            sc          <= '0;
            result_addr <= '0;
            if (cmd == CMD_ALLOC) begin
              if (req_size == '0) begin
                done <= 1'b1; status <= ST_ZERO;
              end else if (req_size > REQ_W'(CHUNK_BYTES - HEADER_BYTES)) begin
                done <= 1'b1; status <= ST_LARGE;
              end
            end else if (is_null || free_size == '0) begin
              done <= 1'b1; status <= ST_IGNORED;
            end
          end
        end
        S_A_NEXT: begin
          if (!(k < n_ch)) begin
            if (chk_last) begin
              done <= 1'b1; status <= ST_NOFIT;
            end else begin
              ch <= ch + CH_W'(1);
              k  <= '0;
            end
          end
        end
        S_A_CHK: begin
          off_f     <= seg_rd.off;
          ret_alloc <= 1'b1;
          if (!fit) begin
            k <= k + CNT_W'(1);
          end else if (live_cnt == LIVE_CW'(LIVE_DEPTH)) begin
            done <= 1'b1; status <= ST_FULL;
          end else begin
            blen <= split ? need : seg_rd.len;
          end
        end
        S_A_SLOT: begin
          if (!live_valid[sc]) begin
            live_valid[sc] <= 1'b1;
            live_cnt       <= live_cnt + LIVE_CW'(1);
            done           <= 1'b1;
            status         <= ST_OK;
            result_addr    <= ADDR_W'(alloc_addr);
          end else begin
            sc <= sc + LIVE_AW'(1);
          end
        end
        S_SD_NEXT: begin
          if (!((k + CNT_W'(1)) < n_ch)) begin
            seg_cnt[ch] <= n_ch - CNT_W'(1);
            sc          <= ret_alloc ? '0 : sc;
          end
        end
        S_SD_WR:  k <= k + CNT_W'(1);
        S_F_LCHK: begin
          ret_alloc <= 1'b0;
          cur_ok    <= 1'b0;
          if (lmatch) begin
            len_f <= live_rd.len;
            ch    <= fstart[GA_W-1:OFF_W];
            off_f <= fstart[OFF_W-1:0];
            k     <= '0;
          end else if (sc == LIVE_AW'(LIVE_DEPTH - 1)) begin
            done <= 1'b1; status <= ST_UNKNOWN;
          end else begin
            sc <= sc + LIVE_AW'(1);
          end
        end
        S_F_SCHK: begin
          if (seg_rd.off > off_f) begin
            cur    <= seg_rd;
            cur_ok <= 1'b1;
          end else begin
            prev <= seg_rd;
            k    <= k + CNT_W'(1);
          end
        end
        S_F_MERGE: begin
          j <= n_ch;
          if (!mprev && !mnext && n_ch >= CNT_W'(TABLE_DEPTH)) begin
            done <= 1'b1; status <= ST_FULL;
          end
        end
        S_SU_NEXT: if (!(j > k)) seg_cnt[ch] <= n_ch + CNT_W'(1);
        S_SU_WR:   j <= j - CNT_W'(1);
        S_F_DONE: begin
          live_valid[sc] <= 1'b0;
          live_cnt       <= live_cnt - LIVE_CW'(1);
          done           <= 1'b1;
          status         <= ST_OK;
        end
        default: ;
      endcase
    end
  end

endmodule
